// ===== hdl/crcat_pkg.sv =====
// shared types, register map and crc helper functions for the byte crc attach unit
package crcat_pkg;

    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;

    typedef enum logic [1:0] {
        REG_POLYNOMIAL  = 2'd0,
        REG_ORDER_BYTES = 2'd1,
        REG_ATTACH_MODE = 2'd2
    } reg_index_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        logic [7:0]  out_byte;
        logic        is_crc_byte;
        logic        end_of_frame;
        logic [31:0] crc_value;
    } out_t;

    typedef struct packed {
        logic [31:0] polynomial;
        logic [2:0]  order_bytes;
        logic        attach_mode;
    } cfg_t;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        last_byte;
        logic [31:0] crc;
    } job_t;

    // order in bytes, clamped to 1..4
    function automatic logic [2:0] eff_order(input logic [2:0] order_bytes);
        logic [2:0] nb;
        case (order_bytes)
            3'd0:    nb = 3'd1;
            3'd1:    nb = 3'd1;
            3'd2:    nb = 3'd2;
            3'd3:    nb = 3'd3;
            default: nb = 3'd4;
        endcase
        return nb;
    endfunction

    // msb-first crc update over one byte, eight xor-shift steps
    function automatic logic [31:0] fold_byte(input logic [31:0] crc_in,
                                              input logic [7:0]  data,
                                              input logic [2:0]  nb,
                                              input logic [31:0] poly);
        logic [31:0] mask;
        logic [31:0] top;
        logic [31:0] ins;
        logic [31:0] crc;
        logic        hi;
        case (nb)
            3'd1: begin
                mask = 32'h0000_00ff;
                top  = 32'h0000_0080;
                ins  = {24'd0, data};
            end
            3'd2: begin
                mask = 32'h0000_ffff;
                top  = 32'h0000_8000;
                ins  = {16'd0, data, 8'd0};
            end
            3'd3: begin
                mask = 32'h00ff_ffff;
                top  = 32'h0080_0000;
                ins  = {8'd0, data, 16'd0};
            end
            default: begin
                mask = 32'hffff_ffff;
                top  = 32'h8000_0000;
                ins  = {data, 24'd0};
            end
        endcase
        crc = (crc_in & mask) ^ ins;
        for (int k = 0; k < 8; k++) begin
            hi  = |(crc & top);
            crc = {crc[30:0], 1'b0} & mask;
            if (hi) begin
                crc = crc ^ (poly & mask);
            end
        end
        return crc;
    endfunction

endpackage

// ===== hdl/configurable_byte_crc_attach_unit.sv =====
// top level of the configurable byte crc attach unit
//
// s_ channel: one data byte per transaction, last_byte marks the end of a frame.
// m_ channel: result transactions. in attach mode every byte is echoed and, after
// the last byte, the crc follows as order_bytes bytes (clamped to 1..4), most
// significant first; the final one carries end_of_frame and crc_value. in checksum
// mode only one result is given per frame, at its end, with the crc in crc_value.
// the crc is folded when a byte is accepted; its result enters the output register
// or, while that is busy, the skid slot. bytes with one result each flow at one
// byte per cycle while the receiver does not stall. a frame end in attach mode
// gives the echoed byte, then the crc bytes, one per cycle while m_ready is high.
// s_ready comes straight from the skid slot register.
// when the receiver stalls, the output holds its result and the skid slot takes
// one more transaction before s_ready falls.
// reset (aresetn low, synchronous) clears the running crc and both slots and sets
// polynomial 0, order_bytes 4 and attach_mode 1. registers: polynomial at 0x0,
// order_bytes at 0x4, attach_mode at 0x8; write only while the unit is idle.
module configurable_byte_crc_attach_unit
    import crcat_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_t                   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_t                  m_data
);

    cfg_t cfg;
    job_t job;
    logic job_push;
    logic accept;

    assign accept = s_valid && s_ready;

    crcat_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    crcat_fold u_fold (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .accept   (accept),
        .item     (s_data),
        .cfg      (cfg),
        .job      (job),
        .job_push (job_push)
    );

    crcat_emit u_emit (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg),
        .job_push (job_push),
        .job      (job),
        .in_ready (s_ready),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_data   (m_data)
    );

endmodule

// ===== hdl/crcat_regs.sv =====
// apb configuration registers: polynomial, order and attach mode
module crcat_regs
    import crcat_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    reg_index_t sel_index;
    logic       wr_en;

    assign pready    = 1'b1;
    assign sel_index = reg_index_t'(paddr[3:2]);
    assign wr_en     = psel && penable && pwrite;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (paddr[3:2])
                REG_POLYNOMIAL:  cfg_next.polynomial  = pwdata;
                REG_ORDER_BYTES: cfg_next.order_bytes = pwdata[2:0];
                REG_ATTACH_MODE: cfg_next.attach_mode = pwdata[0];
                default:         cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb begin
        unique case (sel_index)
            REG_POLYNOMIAL:  prdata = cfg_reg.polynomial;
            REG_ORDER_BYTES: prdata = {29'd0, cfg_reg.order_bytes};
            REG_ATTACH_MODE: prdata = {31'd0, cfg_reg.attach_mode};
            default:         prdata = '0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.polynomial  <= 32'd0;
            cfg_reg.order_bytes <= 3'd4;
            cfg_reg.attach_mode <= 1'b1;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hdl/crcat_fold.sv =====
// running crc register and byte fold at transaction acceptance
module crcat_fold
    import crcat_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic accept,
    input  in_t  item,
    input  cfg_t cfg,
    output job_t job,
    output logic job_push
);

    logic [31:0] crc_reg;
    logic [31:0] crc_next;
    logic [31:0] folded;

    assign folded = fold_byte(crc_reg, item.data_byte, eff_order(cfg.order_bytes),
                              cfg.polynomial);

    assign job.data_byte = item.data_byte;
    assign job.last_byte = item.last_byte;
    assign job.crc       = folded;
    assign job_push      = accept && (cfg.attach_mode || item.last_byte);

    always_comb begin
        crc_next = crc_reg;
        if (accept) begin
            crc_next = item.last_byte ? 32'd0 : folded;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            crc_reg <= 32'd0;
        end else begin
            crc_reg <= crc_next;
        end
    end

endmodule

// ===== hdl/crcat_emit.sv =====
// skid slot and output register, emitting job results one per cycle while m_ready
module crcat_emit
    import crcat_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  cfg_t cfg,
    input  logic job_push,
    input  job_t job,
    output logic in_ready,
    output logic m_valid,
    input  logic m_ready,
    output out_t m_data
);

    logic       a_valid_reg;
    logic       a_valid_next;
    job_t       a_job_reg;
    job_t       a_job_next;
    logic       b_valid_reg;
    logic       b_valid_next;
    job_t       b_job_reg;
    job_t       b_job_next;
    logic [2:0] b_idx_reg;
    logic [2:0] b_idx_next;
    logic [2:0] nb;
    logic [2:0] byte_sel;
    logic       b_final;
    logic       b_done;
    logic       b_free;

    assign nb       = eff_order(cfg.order_bytes);
    assign in_ready = !a_valid_reg;
    assign m_valid  = b_valid_reg;
    assign byte_sel = nb - b_idx_reg;

    assign b_final = !cfg.attach_mode || !b_job_reg.last_byte || (b_idx_reg == nb);
    assign b_done  = b_valid_reg && m_ready && b_final;
    assign b_free  = !b_valid_reg || b_done;

    always_comb begin
        a_valid_next = a_valid_reg;
        a_job_next   = a_job_reg;
        b_valid_next = b_valid_reg;
        b_job_next   = b_job_reg;
        b_idx_next   = b_idx_reg;
        if (b_valid_reg && m_ready) begin
            b_idx_next = b_idx_reg + 3'd1;
        end
        if (b_done) begin
            b_valid_next = 1'b0;
            b_idx_next   = 3'd0;
        end
        if (a_valid_reg) begin
            if (b_free) begin
                b_valid_next = 1'b1;
                b_job_next   = a_job_reg;
                b_idx_next   = 3'd0;
                a_valid_next = 1'b0;
            end
        end else if (job_push) begin
            if (b_free) begin
                b_valid_next = 1'b1;
                b_job_next   = job;
                b_idx_next   = 3'd0;
            end else begin
                a_valid_next = 1'b1;
                a_job_next   = job;
            end
        end
    end

    always_comb begin
        m_data = '0;
        if (cfg.attach_mode) begin
            if (b_idx_reg == 3'd0) begin
                m_data.out_byte = b_job_reg.data_byte;
            end else begin
                case (byte_sel)
                    3'd0:    m_data.out_byte = b_job_reg.crc[7:0];
                    3'd1:    m_data.out_byte = b_job_reg.crc[15:8];
                    3'd2:    m_data.out_byte = b_job_reg.crc[23:16];
                    3'd3:    m_data.out_byte = b_job_reg.crc[31:24];
                    default: m_data.out_byte = 8'd0;
                endcase
                m_data.is_crc_byte  = 1'b1;
                m_data.end_of_frame = (b_idx_reg == nb);
                m_data.crc_value    = (b_idx_reg == nb) ? b_job_reg.crc : 32'd0;
            end
        end else begin
            m_data.end_of_frame = 1'b1;
            m_data.crc_value    = b_job_reg.crc;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            b_idx_reg   <= 3'd0;
        end else begin
            a_valid_reg <= a_valid_next;
            b_valid_reg <= b_valid_next;
            b_idx_reg   <= b_idx_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_job_reg <= a_job_next;
        b_job_reg <= b_job_next;
    end

endmodule

// ===== hdl/crcat_checker.sv =====
// port-level checks for the byte crc attach unit and their bind
module crcat_checker
    import crcat_pkg::*;
(
    input logic aclk,
    input logic aresetn,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input out_t m_data
);

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid && s_ready)
        else $error("outputs not idle after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result changed while stalled");

    a_crc_zero_mid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.end_of_frame |-> m_data.crc_value == 32'd0)
        else $error("crc_value nonzero before end of frame");

    a_last_crc_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.is_crc_byte && m_data.end_of_frame
            |-> m_data.out_byte == m_data.crc_value[7:0])
        else $error("final crc byte disagrees with crc_value");

endmodule

bind configurable_byte_crc_attach_unit crcat_checker u_crcat_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);

// ===== dv/configurable_byte_crc_attach_unit_test.sv =====
// self-checking testbench for the configurable byte crc attach unit
`timescale 1ns / 100ps

module configurable_byte_crc_attach_unit_test;
    import crcat_pkg::*;

    localparam int NUM_DIRECTED  = 22;
    localparam int NUM_PHASES    = 8;
    localparam int PHASE_ITEMS   = 60;
    localparam int SETTLE_CYCLES = 8;
    localparam int TAIL_CYCLES   = 16;
    localparam int LONG_HOLD     = 300;
    localparam int STALL_LIMIT   = 2000;

    typedef struct packed {
        logic  set_cfg;
        cfg_t  cfg;
        in_t   item;
        logic  known;
        out_t  typed;
    } stim_row_t;

    logic                  aclk    = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;
    logic                  s_valid = 1'b0;
    logic                  s_ready;
    in_t                   s_data  = '0;
    logic                  m_valid;
    logic                  m_ready = 1'b0;
    out_t                  m_data;

    cfg_t        cfg_shadow = '{polynomial: 32'h0, order_bytes: 3'd4, attach_mode: 1'b1};
    logic [31:0] running_crc = '0;
    out_t        out_stream_q[$];
    int          mismatch_count = 0;
    int          tx_idle_pct = 0;
    int          rx_stall_pct = 0;
    int          hold_seq = 0;
    int          quiet_cycles = 0;

    stim_row_t directed_rows [NUM_DIRECTED] = '{
        '{1'b0, '0, '{8'hff, 1'b1}, 1'b1, '{8'h00, 1'b1, 1'b1, 32'h0}},
        '{1'b1, '{32'hffff_ffff, 3'd4, 1'b1}, '{8'h00, 1'b1}, 1'b1,
          '{8'h00, 1'b1, 1'b1, 32'h0}},
        '{1'b1, '{32'h04c1_1db7, 3'd4, 1'b1}, '{8'h01, 1'b1}, 1'b1,
          '{8'hb7, 1'b1, 1'b1, 32'h04c1_1db7}},
        '{1'b0, '0, '{8'h31, 1'b0}, 1'b0, '0},
        '{1'b0, '0, '{8'h32, 1'b1}, 1'b0, '0},
        '{1'b1, '{32'hffff_ff07, 3'd1, 1'b1}, '{8'h01, 1'b1}, 1'b1,
          '{8'h07, 1'b1, 1'b1, 32'h0000_0007}},
        '{1'b0, '0, '{8'hff, 1'b0}, 1'b0, '0},
        '{1'b0, '0, '{8'h00, 1'b0}, 1'b0, '0},
        '{1'b0, '0, '{8'h80, 1'b1}, 1'b0, '0},
        '{1'b1, '{32'h0000_1021, 3'd2, 1'b1}, '{8'haa, 1'b0}, 1'b0, '0},
        '{1'b0, '0, '{8'h55, 1'b1}, 1'b0, '0},
        '{1'b1, '{32'h005d_6dcb, 3'd3, 1'b0}, '{8'h12, 1'b0}, 1'b0, '0},
        '{1'b0, '0, '{8'h34, 1'b1}, 1'b0, '0},
        '{1'b1, '{32'hffff_ffff, 3'd0, 1'b0}, '{8'h00, 1'b1}, 1'b1,
          '{8'h00, 1'b0, 1'b1, 32'h0}},
        '{1'b0, '0, '{8'hc3, 1'b1}, 1'b0, '0},
        // frame left open across the next setting change
        '{1'b1, '{32'h1edc_6f41, 3'd7, 1'b1}, '{8'hfe, 1'b0}, 1'b0, '0},
        '{1'b0, '0, '{8'h01, 1'b0}, 1'b0, '0},
        '{1'b1, '{32'h0000_8005, 3'd2, 1'b1}, '{8'h7f, 1'b1}, 1'b0, '0},
        '{1'b1, '{32'h0000_0000, 3'd5, 1'b0}, '{8'h5a, 1'b0}, 1'b0, '0},
        '{1'b0, '0, '{8'ha5, 1'b1}, 1'b0, '0},
        '{1'b1, '{32'h8000_0001, 3'd6, 1'b1}, '{8'hff, 1'b1}, 1'b0, '0},
        '{1'b1, '{32'hffff_ffff, 3'd1, 1'b1}, '{8'h01, 1'b1}, 1'b1,
          '{8'hff, 1'b1, 1'b1, 32'h0000_00ff}}
    };

    configurable_byte_crc_attach_unit dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    initial begin
        forever #4 aclk = ~aclk;
    end

    function automatic int unsigned order_of(input logic [2:0] ob);
        if (ob == 3'd0) begin
            return 1;
        end
        if (ob > 3'd4) begin
            return 4;
        end
        return int'(ob);
    endfunction

    function automatic logic [31:0] crc_fold_byte(input logic [31:0] crc_in,
                                                  input logic [7:0]  b,
                                                  input int unsigned nb,
                                                  input logic [31:0] poly);
        logic [31:0] width_mask;
        logic [31:0] acc;
        int unsigned msb;
        width_mask = 32'((64'd1 << (8 * nb)) - 64'd1);
        msb        = 8 * nb - 1;
        acc        = (crc_in & width_mask) ^ (32'(b) << (8 * (nb - 1)));
        repeat (8) begin
            if (acc[msb]) begin
                acc = ((acc << 1) & width_mask) ^ (poly & width_mask);
            end else begin
                acc = (acc << 1) & width_mask;
            end
        end
        return acc;
    endfunction

    task automatic stream_from_byte(input in_t item, input logic known, input out_t typed);
        int unsigned nb;
        logic [31:0] crc;
        out_t        batch[$];
        nb          = order_of(cfg_shadow.order_bytes);
        crc         = crc_fold_byte(running_crc, item.data_byte, nb, cfg_shadow.polynomial);
        running_crc = crc;
        if (cfg_shadow.attach_mode) begin
            batch.push_back('{item.data_byte, 1'b0, 1'b0, 32'h0});
            if (item.last_byte) begin
                for (int unsigned i = 0; i < nb; i++) begin
                    batch.push_back('{8'(crc >> (8 * (nb - 1 - i))), 1'b1,
                                      (i == nb - 1), (i == nb - 1) ? crc : 32'h0});
                end
            end
        end else if (item.last_byte) begin
            batch.push_back('{8'h00, 1'b0, 1'b1, crc});
        end
        if (item.last_byte) begin
            running_crc = '0;
        end
        if (known && batch.size() > 0) begin
            batch[batch.size() - 1] = typed;
        end
        foreach (batch[i]) begin
            out_stream_q.push_back(batch[i]);
        end
    endtask

    task automatic send_byte(input in_t item, input logic known, input out_t typed);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= item;
        do begin
            @(posedge aclk);
        end while (!s_ready);
        stream_from_byte(item, known, typed);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do begin
            @(posedge aclk);
        end while (out_stream_q.size() != 0);
    endtask

    task automatic reg_write(input reg_index_t idx, input logic [31:0] value);
        psel    <= 1'b1;
        pwrite  <= 1'b1;
        penable <= 1'b0;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge aclk);
        penable <= 1'b1;
        do begin
            @(posedge aclk);
        end while (!pready);
    endtask

    task automatic apply_setting(input cfg_t c);
        wait_drained();
        // checksum frames may still be folding bytes with no result pending
        repeat (SETTLE_CYCLES) @(posedge aclk);
        reg_write(REG_POLYNOMIAL, c.polynomial);
        reg_write(REG_ORDER_BYTES, 32'(c.order_bytes));
        reg_write(REG_ATTACH_MODE, 32'(c.attach_mode));
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        cfg_shadow = c;
    endtask

    always @(posedge aclk) begin
        int hold_seen;
        int hold_left;
        if (hold_seq != hold_seen) begin
            hold_seen = hold_seq;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= rx_stall_pct);
        end
    end

    always @(posedge aclk) begin
        out_t want;
        if (aresetn && m_valid && m_ready) begin
            if (out_stream_q.size() == 0) begin
                $error("unexpected transaction: out_byte %h crc_value %h",
                       m_data.out_byte, m_data.crc_value);
                mismatch_count++;
            end else begin
                want = out_stream_q.pop_front();
                if (m_data.out_byte !== want.out_byte) begin
                    $error("out_byte expected %h actual %h", want.out_byte, m_data.out_byte);
                    mismatch_count++;
                end
                if (m_data.is_crc_byte !== want.is_crc_byte) begin
                    $error("is_crc_byte expected %b actual %b",
                           want.is_crc_byte, m_data.is_crc_byte);
                    mismatch_count++;
                end
                if (m_data.end_of_frame !== want.end_of_frame) begin
                    $error("end_of_frame expected %b actual %b",
                           want.end_of_frame, m_data.end_of_frame);
                    mismatch_count++;
                end
                if (m_data.crc_value !== want.crc_value) begin
                    $error("crc_value expected %h actual %h", want.crc_value, m_data.crc_value);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        cfg_t phase_cfg;
        in_t  item;
        int   frame_left;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < NUM_DIRECTED; r++) begin
            if (directed_rows[r].set_cfg) begin
                apply_setting(directed_rows[r].cfg);
            end
            send_byte(directed_rows[r].item, directed_rows[r].known, directed_rows[r].typed);
        end

        frame_left = 0;
        for (int p = 0; p < NUM_PHASES; p++) begin
            phase_cfg.polynomial  = $urandom();
            phase_cfg.order_bytes = ($urandom_range(0, 9) < 8) ? 3'($urandom_range(1, 4))
                                                               : 3'($urandom_range(0, 7));
            phase_cfg.attach_mode = ($urandom_range(0, 3) != 0);
            if (p == 0) begin
                phase_cfg = '{32'hffff_ffff, 3'd1, 1'b1};
            end else if (p == 1) begin
                phase_cfg = '{32'h0000_0000, 3'd4, 1'b0};
            end
            apply_setting(phase_cfg);
            case (p % 4)
                0: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1: begin
                    tx_idle_pct  = 57;
                    rx_stall_pct = 0;
                end
                2: begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 57;
                end
                default: begin
                    tx_idle_pct  = 26;
                    rx_stall_pct = 26;
                end
            endcase
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                if (p == 4 && n == 20) begin
                    hold_seq <= hold_seq + 1;
                end
                if (p == 5 && n == 30) begin
                    wait_drained();
                end
                if (frame_left == 0) begin
                    frame_left = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 20)
                                                             : $urandom_range(1, 6);
                end
                item.data_byte = 8'($urandom_range(0, 255));
                item.last_byte = (frame_left == 1);
                if ($urandom_range(0, 9) == 0) begin
                    item.last_byte = 1'($urandom_range(0, 1));
                end
                frame_left = item.last_byte ? 0 : frame_left - 1;
                send_byte(item, 1'b0, '0);
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
